// ===== hdl/ltpd_pkg.sv =====
// Package: shared types and constants for the length/type prefixed deframer.
package ltpd_pkg;

    localparam int unsigned HEADER_BYTES  = 8;
    localparam int unsigned WORD_BYTES    = HEADER_BYTES / 2;
    localparam int unsigned HDR_CNT_W     = $clog2(WORD_BYTES);
    localparam logic [31:0] MAX_LEN_RESET = 32'd4096;

    typedef enum logic [1:0] {
        KIND_DATA     = 2'd0,
        KIND_EMPTY    = 2'd1,
        KIND_OVERSIZE = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic [31:0] frame_type;
        logic [31:0] msg_length;
        logic        last;
    } t_result;

endpackage

// ===== hdl/ltpd_ifs.sv =====
// Interfaces: byte input, result output and configuration write channels.
interface ltpd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

interface ltpd_res_if;
    logic              valid;
    logic              ready;
    ltpd_pkg::t_kind   kind;
    logic [7:0]        data_byte;
    logic [31:0]       frame_type;
    logic [31:0]       msg_length;
    logic              last;
    modport source (output valid, output kind, output data_byte, output frame_type,
                    output msg_length, output last, input ready);
    modport sink (input valid, input kind, input data_byte, input frame_type,
                  input msg_length, input last, output ready);
endinterface

interface ltpd_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] max_length;
    modport source (output valid, output max_length, input ready);
    modport sink (input valid, input max_length, output ready);
endinterface

// ===== hdl/length_type_prefixed_deframer.sv =====
// Top level: length/type prefixed deframer, one byte in, zero or one result out.
// Path: a byte accepted into the input register passes through the parser and its
// result is loaded into the result register once that register is free to take it.
// Throughput: one byte per cycle while the result register is free, set by the parser
// stage between the input register and the result register; a held result stalls it.
// Reset: synchronous, clears the parser to the length phase, empties both
// stages and sets max_length to 4096; no clearing pass.
module length_type_prefixed_deframer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ltpd_byte_if.sink   i_rx,
    ltpd_res_if.source  o_res,
    ltpd_cfg_if.sink    i_cfg
);
    import ltpd_pkg::*;

    logic [31:0] r_max_len;
    logic        w_in_valid;
    logic        w_out_free;
    logic        w_advance;
    logic [7:0]  w_byte;
    logic        w_res_valid;
    t_result     w_res;
    t_result     w_out_res;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len <= MAX_LEN_RESET;
        end else if (i_cfg.valid && i_cfg.ready) begin
            r_max_len <= i_cfg.max_length;
        end
    end

    assign w_advance = w_in_valid && w_out_free;

    ltpd_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_rx.valid),
        .o_ready (i_rx.ready),
        .i_byte  (i_rx.rx_byte),
        .i_take  (w_advance),
        .o_valid (w_in_valid),
        .o_byte  (w_byte)
    );

    ltpd_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_advance    (w_advance),
        .i_byte       (w_byte),
        .i_max_length (r_max_len),
        .o_res_valid  (w_res_valid),
        .o_res        (w_res)
    );

    ltpd_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_advance && w_res_valid),
        .i_res   (w_res),
        .i_ready (o_res.ready),
        .o_valid (o_res.valid),
        .o_res   (w_out_res),
        .o_free  (w_out_free)
    );

    assign o_res.kind       = w_out_res.kind;
    assign o_res.data_byte  = w_out_res.data_byte;
    assign o_res.frame_type = w_out_res.frame_type;
    assign o_res.msg_length = w_out_res.msg_length;
    assign o_res.last       = w_out_res.last;
endmodule

// ===== hdl/ltpd_in_stage.sv =====
// Input register stage: holds one received byte until the parser takes it.
module ltpd_in_stage (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_byte,
    input  logic       i_take,
    output logic       o_valid,
    output logic [7:0] o_byte
);
    logic       r_valid;
    logic [7:0] r_byte;
    logic       n_valid;

    assign o_ready = !r_valid || i_take;
    assign n_valid = (i_valid && o_ready) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
        if (i_valid && o_ready) begin
            r_byte <= i_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;
endmodule

// ===== hdl/ltpd_parser.sv =====
// Frame parser: header assembly, length check and payload tagging.
module ltpd_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_advance,
    input  logic [7:0]        i_byte,
    input  logic [31:0]       i_max_length,
    output logic              o_res_valid,
    output ltpd_pkg::t_result o_res
);
    import ltpd_pkg::*;

    typedef enum logic [1:0] {
        PH_LEN  = 2'd0,
        PH_TYPE = 2'd1,
        PH_DATA = 2'd2,
        PH_STOP = 2'd3
    } t_phase;

    t_phase                 r_phase, n_phase;
    logic [HDR_CNT_W-1:0]   r_hdr_cnt, n_hdr_cnt;
    logic [31:0]            r_len, n_len;
    logic [31:0]            r_type, n_type;
    logic [31:0]            r_rem, n_rem;
    logic [31:0]            w_shifted_len;
    logic [31:0]            w_shifted_type;
    logic                   w_word_done;

    assign w_shifted_len  = {i_byte, r_len[31:8]};
    assign w_shifted_type = {i_byte, r_type[31:8]};
    assign w_word_done    = (r_hdr_cnt == HDR_CNT_W'(WORD_BYTES - 1));

    always_comb begin
        n_phase     = r_phase;
        n_hdr_cnt   = r_hdr_cnt;
        n_len       = r_len;
        n_type      = r_type;
        n_rem       = r_rem;
        o_res_valid = 1'b0;
        o_res       = '{kind: KIND_DATA, data_byte: 8'd0, frame_type: 32'd0,
                        msg_length: 32'd0, last: 1'b0};
        case (r_phase)
            PH_LEN: begin
                n_len     = w_shifted_len;
                n_hdr_cnt = r_hdr_cnt + HDR_CNT_W'(1);
                if (w_word_done) begin
                    if (w_shifted_len > i_max_length) begin
                        n_phase          = PH_STOP;
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_OVERSIZE;
                        o_res.msg_length = w_shifted_len;
                    end else begin
                        n_phase = PH_TYPE;
                    end
                end
            end
            PH_TYPE: begin
                n_type    = w_shifted_type;
                n_hdr_cnt = r_hdr_cnt + HDR_CNT_W'(1);
                if (w_word_done) begin
                    if (r_len == 32'd0) begin
                        n_phase          = PH_LEN;
                        o_res_valid      = 1'b1;
                        o_res.kind       = KIND_EMPTY;
                        o_res.frame_type = w_shifted_type;
                        o_res.last       = 1'b1;
                    end else begin
                        n_rem   = r_len;
                        n_phase = PH_DATA;
                    end
                end
            end
            PH_DATA: begin
                n_rem            = r_rem - 32'd1;
                o_res_valid      = 1'b1;
                o_res.kind       = KIND_DATA;
                o_res.data_byte  = i_byte;
                o_res.frame_type = r_type;
                o_res.msg_length = r_len;
                if (r_rem == 32'd1) begin
                    n_phase    = PH_LEN;
                    o_res.last = 1'b1;
                end
            end
            default: begin
                n_phase = PH_STOP;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_LEN;
            r_hdr_cnt <= '0;
            r_len     <= 32'd0;
            r_type    <= 32'd0;
            r_rem     <= 32'd0;
        end else if (i_advance) begin
            r_phase   <= n_phase;
            r_hdr_cnt <= n_hdr_cnt;
            r_len     <= n_len;
            r_type    <= n_type;
            r_rem     <= n_rem;
        end
    end
endmodule

// ===== hdl/ltpd_out_stage.sv =====
// Result register stage: holds one result until the sink takes it.
module ltpd_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  ltpd_pkg::t_result i_res,
    input  logic              i_ready,
    output logic              o_valid,
    output ltpd_pkg::t_result o_res,
    output logic              o_free
);
    import ltpd_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (i_load) begin
            r_res <= i_res;
        end
    end

    assign o_valid = r_valid;
    assign o_res   = r_res;
endmodule
